// ===== hw/rtl/msw_pkg.sv =====
package msw_pkg;

    // parse phase codes
    localparam logic [1:0] PHASE_SUBHDR = 2'd0;
    localparam logic [1:0] PHASE_LEN1   = 2'd1;
    localparam logic [1:0] PHASE_LEN2   = 2'd2;
    localparam logic [1:0] PHASE_DONE   = 2'd3;

    // subheader byte layout and channel id ranges
    localparam int unsigned EXT_BIT      = 5;
    localparam int unsigned LEN_LONG_BIT = 7;
    localparam logic [4:0]  LCID_COMMON     = 5'd0;
    localparam logic [4:0]  LCID_SIGNAL_MAX = 5'd2;
    localparam logic [4:0]  LCID_BEARER_MAX = 5'd10;
    localparam logic [4:0]  LCID_FIXED_MIN  = 5'd27;

    // subheader count saturates here
    localparam logic [3:0]  COUNT_MAX        = 4'd15;
    localparam logic [3:0]  MAX_SUBHDR_RESET = 4'd12;

    // one byte of the transport block
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    // per-byte parse result
    typedef struct packed {
        logic       subheader_seen;
        logic [4:0] channel_id;
        logic       has_common;
        logic       has_signalling;
        logic       has_bearer;
        logic       parse_done;
        logic       block_end;
    } parse_res_t;

endpackage

// ===== hw/rtl/msw_ifs.sv =====
// byte request channel
interface msw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// parse result channel
interface msw_out_if;
    logic       valid;
    logic       ready;
    logic       subheader_seen;
    logic [4:0] channel_id;
    logic       has_common;
    logic       has_signalling;
    logic       has_bearer;
    logic       parse_done;
    logic       block_end;

    modport source (output valid, output subheader_seen, output channel_id,
                    output has_common, output has_signalling, output has_bearer,
                    output parse_done, output block_end, input ready);
    modport sink   (input valid, input subheader_seen, input channel_id,
                    input has_common, input has_signalling, input has_bearer,
                    input parse_done, input block_end, output ready);
endinterface

// ===== hw/rtl/msw_parser.sv =====
module msw_parser
    import msw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  byte_req_t  req,
    input  logic [3:0] max_subheaders,
    output parse_res_t res
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic       common_reg;
    logic       common_next;
    logic       signal_reg;
    logic       signal_next;
    logic       bearer_reg;
    logic       bearer_next;

    logic [4:0] lcid;
    logic       ext;
    logic [3:0] count_inc;
    logic       limit_hit;
    logic [1:0] after_subhdr;

    assign lcid      = req.data_byte[4:0];
    assign ext       = req.data_byte[EXT_BIT];
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 4'd1 : count_reg;
    assign limit_hit = (count_reg >= max_subheaders);
    assign after_subhdr = limit_hit ? PHASE_DONE : PHASE_SUBHDR;

    // next parse state for this byte
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        common_next = common_reg;
        signal_next = signal_reg;
        bearer_next = bearer_reg;
        res.subheader_seen = 1'b0;
        res.channel_id     = '0;
        unique case (phase_reg)
            PHASE_SUBHDR:
            begin
                res.subheader_seen = 1'b1;
                res.channel_id     = lcid;
                if (lcid == LCID_COMMON)
                begin
                    common_next = 1'b1;
                end
                else if (lcid <= LCID_SIGNAL_MAX)
                begin
                    signal_next = 1'b1;
                end
                else if (lcid <= LCID_BEARER_MAX)
                begin
                    bearer_next = 1'b1;
                end
                count_next = count_inc;
                if (!ext || (count_inc >= max_subheaders))
                begin
                    phase_next = PHASE_DONE;
                end
                else if (lcid < LCID_FIXED_MIN)
                begin
                    phase_next = PHASE_LEN1;
                end
                else
                begin
                    phase_next = PHASE_SUBHDR;
                end
            end
            PHASE_LEN1:
            begin
                phase_next = req.data_byte[LEN_LONG_BIT] ? PHASE_LEN2 : after_subhdr;
            end
            PHASE_LEN2:
            begin
                phase_next = after_subhdr;
            end
            PHASE_DONE:
            begin
                phase_next = PHASE_DONE;
            end
            default:
            begin
                phase_next = PHASE_DONE;
            end
        endcase
        res.has_common     = common_next;
        res.has_signalling = signal_next;
        res.has_bearer     = bearer_next;
        res.parse_done     = (phase_next == PHASE_DONE);
        res.block_end      = req.last_byte;
    end

    // parse state, cleared after the last byte of a block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_SUBHDR;
            count_reg  <= '0;
            common_reg <= 1'b0;
            signal_reg <= 1'b0;
            bearer_reg <= 1'b0;
        end
        else if (step)
        begin
            if (req.last_byte)
            begin
                phase_reg  <= PHASE_SUBHDR;
                count_reg  <= '0;
                common_reg <= 1'b0;
                signal_reg <= 1'b0;
                bearer_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                common_reg <= common_next;
                signal_reg <= signal_next;
                bearer_reg <= bearer_next;
            end
        end
    end

endmodule

// ===== hw/rtl/mac_subheader_lcid_walker_top.sv =====
// MAC subheader walker for decoded downlink transport blocks.
// in_ch carries one byte of the block per request, with last_byte set on the
// final byte; the byte after it starts a new block. out_ch returns exactly one
// result per byte, in order: whether the byte was a subheader, its channel id,
// the running common/signalling/bearer flags, parse_done and block_end.
// The subheader limit is written through cfg_wr_en/cfg_wr_data, and the user must
// write it only while idle, as the block does not enforce this; it resets to 12.
// A byte accepted on in_ch goes through one input register and one result
// register before it is offered on out_ch. Throughput is one byte per cycle
// while out_ch does not stall; the parse state is updated in the same cycle as
// the input register hands its byte to the result register.
// If out_ch stalls, the result register holds, the input register fills, and
// in_ch.ready drops; nothing is lost and both sides resume at full rate.
// Reset empties both registers, sets the limit to 12 and returns the parser
// to the start of a block with all flags clear.
module mac_subheader_lcid_walker_top
    import msw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    msw_in_if.sink     in_ch,
    msw_out_if.source  out_ch
);

    logic [3:0] max_subheaders_reg;
    logic       in_valid_reg;
    byte_req_t  in_data_reg;
    logic       out_valid_reg;
    parse_res_t out_data_reg;
    parse_res_t parse_res;
    logic       advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_subheaders_reg <= MAX_SUBHDR_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_subheaders_reg <= cfg_wr_data;
        end
    end

    // pipeline handshake
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_data_reg.data_byte <= in_ch.data_byte;
            in_data_reg.last_byte <= in_ch.last_byte;
        end
    end

    msw_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .req            (in_data_reg),
        .max_subheaders (max_subheaders_reg),
        .res            (parse_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= parse_res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.subheader_seen = out_data_reg.subheader_seen;
    assign out_ch.channel_id     = out_data_reg.channel_id;
    assign out_ch.has_common     = out_data_reg.has_common;
    assign out_ch.has_signalling = out_data_reg.has_signalling;
    assign out_ch.has_bearer     = out_data_reg.has_bearer;
    assign out_ch.parse_done     = out_data_reg.parse_done;
    assign out_ch.block_end      = out_data_reg.block_end;

endmodule

// ===== tb/subheader_parse_scoreboard.sv =====
module subheader_parse_scoreboard
    import msw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    msw_in_if           byte_ch,
    msw_out_if          res_ch,
    output int unsigned fail_count,
    output int unsigned results_owed
);

    // predicted parser state, kept apart from the block
    logic [1:0] walk_phase;
    logic [3:0] hdr_count;
    logic [3:0] hdr_limit;
    logic       common_seen;
    logic       signal_seen;
    logic       bearer_seen;

    parse_res_t  owed_results [$];
    int unsigned reported;

    // clear the per-block state
    task automatic start_block();
        walk_phase  = PHASE_SUBHDR;
        hdr_count   = '0;
        common_seen = 1'b0;
        signal_seen = 1'b0;
        bearer_seen = 1'b0;
    endtask

    // phase once a subheader and its length bytes are finished
    function automatic logic [1:0] phase_after_subheader();
        return (hdr_count >= hdr_limit) ? PHASE_DONE : PHASE_SUBHDR;
    endfunction

    // advance the walk by one byte and form its result
    task automatic walk_byte(input logic [7:0] b, input logic last, output parse_res_t res);
        logic [4:0] id;
        logic       seen;
        id   = '0;
        seen = 1'b0;
        case (walk_phase)
            PHASE_SUBHDR:
            begin
                seen = 1'b1;
                id   = b[4:0];
                if (id == LCID_COMMON)
                begin
                    common_seen = 1'b1;
                end
                else if (id <= LCID_SIGNAL_MAX)
                begin
                    signal_seen = 1'b1;
                end
                else if (id <= LCID_BEARER_MAX)
                begin
                    bearer_seen = 1'b1;
                end
                if (hdr_count < COUNT_MAX)
                begin
                    hdr_count = hdr_count + 4'd1;
                end
                // limit check comes before the length field, so it wins
                if (!b[EXT_BIT])
                begin
                    walk_phase = PHASE_DONE;
                end
                else if (hdr_count >= hdr_limit)
                begin
                    walk_phase = PHASE_DONE;
                end
                else if (id < LCID_FIXED_MIN)
                begin
                    walk_phase = PHASE_LEN1;
                end
                else
                begin
                    walk_phase = PHASE_SUBHDR;
                end
            end
            PHASE_LEN1:
            begin
                walk_phase = b[LEN_LONG_BIT] ? PHASE_LEN2 : phase_after_subheader();
            end
            PHASE_LEN2:
            begin
                walk_phase = phase_after_subheader();
            end
            default:
            begin
                walk_phase = PHASE_DONE;
            end
        endcase
        res.subheader_seen = seen;
        res.channel_id     = id;
        res.has_common     = common_seen;
        res.has_signalling = signal_seen;
        res.has_bearer     = bearer_seen;
        res.parse_done     = (walk_phase == PHASE_DONE);
        res.block_end      = last;
        if (last)
        begin
            start_block();
        end
    endtask

    // predict on each byte request, compare on each result request
    always @(posedge clk or negedge rst_n)
    begin : watch
        parse_res_t want;
        parse_res_t got;
        int unsigned fails;
        if (!rst_n)
        begin
            start_block();
            hdr_limit = MAX_SUBHDR_RESET;
            owed_results.delete();
            reported = 0;
            fail_count   <= 0;
            results_owed <= 0;
        end
        else
        begin
            fails = fail_count;
            if (cfg_wr_en)
            begin
                hdr_limit = cfg_wr_data;
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                walk_byte(byte_ch.data_byte, byte_ch.last_byte, want);
                owed_results.push_back(want);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.subheader_seen, res_ch.channel_id, res_ch.has_common,
                       res_ch.has_signalling, res_ch.has_bearer, res_ch.parse_done,
                       res_ch.block_end};
                if (owed_results.size() == 0)
                begin
                    fails++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected result: seen=%0d id=%0d com=%0d sig=%0d bear=%0d done=%0d end=%0d",
                                 got.subheader_seen, got.channel_id, got.has_common,
                                 got.has_signalling, got.has_bearer, got.parse_done,
                                 got.block_end);
                    end
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.subheader_seen !== want.subheader_seen ||
                        got.channel_id     !== want.channel_id     ||
                        got.has_common     !== want.has_common     ||
                        got.has_signalling !== want.has_signalling ||
                        got.has_bearer     !== want.has_bearer     ||
                        got.parse_done     !== want.parse_done     ||
                        got.block_end      !== want.block_end)
                    begin
                        fails++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("mismatch: expected seen=%0d id=%0d com=%0d sig=%0d bear=%0d done=%0d end=%0d",
                                     want.subheader_seen, want.channel_id, want.has_common,
                                     want.has_signalling, want.has_bearer, want.parse_done,
                                     want.block_end);
                            $display("          actual   seen=%0d id=%0d com=%0d sig=%0d bear=%0d done=%0d end=%0d",
                                     got.subheader_seen, got.channel_id, got.has_common,
                                     got.has_signalling, got.has_bearer, got.parse_done,
                                     got.block_end);
                        end
                    end
                end
            end
            fail_count   <= fails;
            results_owed <= owed_results.size();
        end
    end

endmodule

// ===== tb/mac_subheader_lcid_walker_top_tb.sv =====
module mac_subheader_lcid_walker_top_tb
    import msw_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BYTES = 1330;
    localparam int unsigned PHASES       = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [3:0]  cfg_wr_data;

    msw_in_if  byte_ch();
    msw_out_if res_ch();

    int unsigned fail_count;
    int unsigned results_owed;
    int unsigned bytes_sent = 0;
    int unsigned cycles     = 0;
    int unsigned stall_left = 0;
    bit          idle_on    = 1'b1;

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    mac_subheader_lcid_walker_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (byte_ch),
        .out_ch      (res_ch)
    );

    subheader_parse_scoreboard parse_sb (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .byte_ch      (byte_ch),
        .res_ch       (res_ch),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // result side: random stall after each accepted result while idle_on is set
    always @(posedge clk)
    begin : result_ready
        int unsigned stall_draw;
        if (res_ch.valid && res_ch.ready)
        begin
            stall_draw = idle_on ? $urandom_range(0, 9) : 0;
            stall_left   <= stall_draw;
            res_ch.ready <= (stall_draw == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= (stall_left == 1);
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // run time guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one byte request, with a random gap in front of it while idle_on is set
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_block(input logic [7:0] blk [$]);
        for (int i = 0; i < blk.size(); i++)
        begin
            send_byte(blk[i], i == blk.size() - 1);
        end
    endtask

    // hold off until every result has come back
    task automatic drain();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [3:0] limit);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // random block: mostly well-formed subheader chains, some noise and cut blocks
    task automatic make_block(output logic [7:0] blk [$]);
        int unsigned kind;
        int unsigned n_hdr;
        int unsigned cut;
        logic [4:0]  id;
        logic [7:0]  b;
        logic [7:0]  len;
        blk  = {};
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom));
        end
        else
        begin
            n_hdr = $urandom_range(1, 16);
            for (int i = 0; i < n_hdr; i++)
            begin
                id = $urandom_range(0, 1) ? 5'($urandom_range(0, 10)) : 5'($urandom);
                b  = 8'($urandom);
                b[4:0]    = id;
                b[EXT_BIT] = (i != n_hdr - 1);
                blk.push_back(b);
                if (b[EXT_BIT] && id < LCID_FIXED_MIN)
                begin
                    len = 8'($urandom);
                    blk.push_back(len);
                    if (len[LEN_LONG_BIT])
                    begin
                        blk.push_back(8'($urandom));
                    end
                end
            end
            repeat ($urandom_range(0, 6)) blk.push_back(8'($urandom));
            // block cut short inside the region
            if (kind == 2)
            begin
                cut = $urandom_range(1, blk.size());
                while (blk.size() > cut) void'(blk.pop_back());
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [7:0]  blk [$];
        logic [3:0]  limit;
        int unsigned quota;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        res_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: every id class, short and long lengths, fixed-size ids,
        // stop on clear extension bit, bytes after done
        blk = {8'h20, 8'h80, 8'hFF, 8'h21, 8'h7F, 8'h3F, 8'h3B, 8'h2A, 8'h00, 8'h1A,
               8'hFF, 8'h00};
        send_block(blk);
        // one-byte block
        blk = {8'h03};
        send_block(blk);
        // block ends inside a long length field
        blk = {8'h22, 8'h81};
        send_block(blk);
        // upper bits set on subheaders
        blk = {8'hE9, 8'h40, 8'hDF};
        send_block(blk);

        // limit of one: length field after the limiting subheader is ignored
        write_limit(4'd1);
        blk = {8'h25, 8'h05, 8'h00};
        send_block(blk);
        // zero limit behaves like one
        write_limit(4'd0);
        blk = {8'h24, 8'h10};
        send_block(blk);

        // random phases over several limits
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: limit = 4'd15;
                1: limit = 4'd1;
                2: limit = 4'd0;
                4: limit = MAX_SUBHDR_RESET;
                6: limit = 4'd15;
                default: limit = 4'($urandom_range(1, 15));
            endcase
            write_limit(limit);
            quota = bytes_sent + RANDOM_BYTES / PHASES;
            while (bytes_sent < quota)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                make_block(blk);
                send_block(blk);
            end
        end

        idle_on = 1'b1;
        drain();
        repeat (5) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
